// ----- src/ipg_pkg.sv -----
// Shared constants, types and register codes for the image pyramid gradient block.
`default_nettype none
package ipg_pkg;

    localparam int DIM_W      = 11;
    localparam int PIX_W      = 16;
    localparam int POS_W      = 10;
    localparam int LVL_W      = 3;
    localparam int GRAD_W     = 17;
    localparam int SQ_W       = 33;
    localparam int NLEV_W     = 4;
    localparam int TDATA_W    = 112;
    localparam int CFG_IDX_W  = 2;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_LEVELS_DEF = 6;
    localparam int MAX_HEIGHT     = 1024;
    localparam int FIFO_DEPTH     = 8;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;
    localparam logic [LVL_W-1:0] LEVELS_RST = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 2'd2;

    // Everything one level step yields: the pixel above (res1) and a last-row pixel (res2).
    typedef struct packed {
        logic                     res1_v;
        logic                     res2_v;
        logic                     gvalid;
        logic                     cont;
        logic [POS_W-1:0]         col;
        logic [POS_W-1:0]         row;
        logic [PIX_W-1:0]         inten1;
        logic [PIX_W-1:0]         inten2;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [SQ_W-1:0]          gsq;
    } bundle_t;

    typedef struct packed {
        logic [LVL_W-1:0]         level;
        logic [POS_W-1:0]         col;
        logic [POS_W-1:0]         row;
        logic [PIX_W-1:0]         inten;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [SQ_W-1:0]          gsq;
        logic                     gvalid;
    } res_t;

endpackage
`default_nettype wire

// ----- src/image_pyramid_gradient.sv -----
// Path: a pixel goes through each level cell's s1, s2 and s3 registers into its result queue;
//   a level above zero gets its pixel from the handoff register of the level below it.
// Input: after each accepted pixel a cell makes a second ring read before it takes another
//   (two ring read ports per level cell); a full result queue or a pending handoff also stalls it.
// Reset: frame position of every level goes to zero, size 640x480 with 6 levels;
//   row ring contents are not cleared and are never read before being written in a frame.
`default_nettype none
module image_pyramid_gradient
    import ipg_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [PIX_W-1:0]     s_axis_tdata,   // [15:0] pixel_value
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // level[2:0] col[12:3] row[22:13] intensity[38:23] grad_x[55:39] grad_y[72:56]
    // grad_sq[105:73] grad_valid[106], zero fill above
    output logic [TDATA_W-1:0]        m_axis_tdata,
    output logic                      m_axis_tlast,   // last_of_run
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data
);

    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [LVL_W-1:0]  levels_reg;
    logic              cfg_wr, restart;
    logic [DIM_W-1:0]  w0, h0;
    logic [NLEV_W-1:0] nlev;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb begin
        unique case (cfg_index)
            REG_WIDTH, REG_HEIGHT, REG_LEVELS: restart = cfg_wr;
            default:                           restart = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            levels_reg <= LEVELS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_LEVELS: levels_reg <= cfg_data[LVL_W-1:0];
                default:    ;
            endcase
        end
    end

    assign w0 = (int'(width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign h0 = (int'(height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_reg;
    assign nlev = (levels_reg == '0) ? NLEV_W'(1)
                : (int'(levels_reg) > MAX_LEVELS) ? NLEV_W'(MAX_LEVELS)
                : NLEV_W'(levels_reg);

    logic             hand_valid [MAX_LEVELS+1];
    logic             hand_ready [MAX_LEVELS+1];
    logic [PIX_W-1:0] hand_data  [MAX_LEVELS+1];
    logic             head_valid [MAX_LEVELS];
    bundle_t          head       [MAX_LEVELS];
    logic             pop        [MAX_LEVELS];

    assign hand_valid[0]          = s_axis_tvalid;
    assign hand_data[0]           = s_axis_tdata;
    assign s_axis_tready          = hand_ready[0];
    assign hand_ready[MAX_LEVELS] = 1'b0;

    for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_cell
        ipg_cell #(
            .LVL        (l),
            .MAX_WIDTH  (MAX_WIDTH),
            .MAX_LEVELS (MAX_LEVELS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .restart    (restart),
            .w0         (w0),
            .h0         (h0),
            .nlev       (nlev),
            .in_valid   (hand_valid[l]),
            .in_ready   (hand_ready[l]),
            .in_data    (hand_data[l]),
            .nxt_valid  (hand_valid[l+1]),
            .nxt_ready  (hand_ready[l+1]),
            .nxt_data   (hand_data[l+1]),
            .head_valid (head_valid[l]),
            .head       (head[l]),
            .pop        (pop[l])
        );
    end

    res_t m_res;

    ipg_seq #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_res      (m_res),
        .m_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, m_res.gvalid, m_res.gsq, m_res.gy, m_res.gx, m_res.inten,
                           m_res.row, m_res.col, m_res.level};

endmodule
`default_nettype wire

// ----- src/ipg_cell.sv -----
// One pyramid level: row ring, gradient and 2x2 mean, handoff to the next level, result queue.
`default_nettype none
module ipg_cell
    import ipg_pkg::*;
#(
    parameter int LVL        = 0,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              restart,
    input  wire logic [DIM_W-1:0]  w0,
    input  wire logic [DIM_W-1:0]  h0,
    input  wire logic [NLEV_W-1:0] nlev,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [PIX_W-1:0]  in_data,
    output logic                   nxt_valid,
    input  wire logic              nxt_ready,
    output logic [PIX_W-1:0]       nxt_data,
    output logic                   head_valid,
    output bundle_t                head,
    input  wire logic              pop
);

    localparam int DEPTH_L = 2 * (MAX_WIDTH >> LVL) + 1;
    localparam int AW      = $clog2(DEPTH_L);
    localparam int FW      = $clog2(FIFO_DEPTH);

    function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] p, input logic [AW:0] k,
                                                input logic [AW:0] sp);
        logic [AW:0] t;
        t = {1'b0, p} + sp - k;
        if (t >= sp) t = t - sp;
        return t[AW-1:0];
    endfunction

    logic [DIM_W-1:0] wl, hl, wn, hn;
    logic             active, more;
    logic [AW:0]      wl_a, span;

    assign wl     = w0 >> LVL;
    assign hl     = h0 >> LVL;
    assign wn     = w0 >> (LVL + 1);
    assign hn     = h0 >> (LVL + 1);
    assign active = (wl != '0) && (hl != '0);
    assign more   = (LVL + 1) < int'(nlev);
    assign wl_a   = (AW+1)'(wl);
    assign span   = (wl_a << 1) + (AW+1)'(1);

    logic [DIM_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic             ph_reg, st2_reg, s2_valid_reg, s3_valid_reg;
    logic [PIX_W-1:0] s1_cur_reg;
    logic [DIM_W-1:0] s1_col_reg, s1_row_reg;
    logic [AW-1:0]    s1_pos_reg;
    logic             s1_r1v_reg, s1_r2v_reg, s1_gv_reg, s1_prod_reg;
    logic [PIX_W-1:0] q0_reg, q1_reg, bwl_reg, b1_reg, bw1_reg;
    bundle_t          s2_reg, s3_reg, s2_next;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg;
    logic             nxt_valid_reg;
    logic [PIX_W-1:0] nxt_data_reg;
    logic [PIX_W-1:0] ring [DEPTH_L];
    bundle_t          fifo [FIFO_DEPTH];
    logic [FW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [FW:0]      cnt_reg, infl_reg;

    logic             f_r1v, f_r2v, f_gv, prod_new, col_last, row_last;
    logic             credit_ok, hand_ok, acc, acc_act, handoff;
    logic [AW-1:0]    rd0_addr, rd1_addr;
    logic [PIX_W+1:0] avg_sum;
    logic signed [2*GRAD_W-1:0] px, py;
    bundle_t          push_b;

    assign f_r1v    = row_reg != '0;
    assign f_gv     = row_reg >= DIM_W'(2);
    assign f_r2v    = ({1'b0, row_reg} + 1'b1) == {1'b0, hl};
    assign prod_new = more && col_reg[0] && row_reg[0] && ((col_reg >> 1) < wn)
                      && ((row_reg >> 1) < hn);
    assign col_last = ({1'b0, col_reg} + 1'b1) >= {1'b0, wl};
    assign row_last = ({1'b0, row_reg} + 1'b1) >= {1'b0, hl};

    assign credit_ok = ({1'b0, cnt_reg} + {1'b0, infl_reg}) < (FW+2)'(FIFO_DEPTH);
    assign hand_ok   = !prod_new || (!nxt_valid_reg && !(st2_reg && s1_prod_reg));
    assign in_ready  = !active || (!ph_reg && credit_ok && hand_ok);
    assign acc       = in_valid && in_ready;
    assign acc_act   = acc && active;
    assign handoff   = st2_reg && s1_prod_reg;

    assign rd0_addr = ph_reg ? back_addr(s1_pos_reg, wl_a - (AW+1)'(1), span)
                             : back_addr(pos_reg, wl_a, span);
    assign rd1_addr = back_addr(pos_reg, wl_a << 1, span);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        pos_next = pos_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
            pos_next = '0;
        end else if (acc_act) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
            if (col_last && row_last) begin
                pos_next = '0;
            end else if (({1'b0, pos_reg} + 1'b1) == span) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_comb begin
        s2_next        = '0;
        s2_next.res1_v = s1_r1v_reg;
        s2_next.res2_v = s1_r2v_reg;
        s2_next.gvalid = s1_gv_reg;
        s2_next.cont   = s1_prod_reg;
        s2_next.col    = s1_col_reg[POS_W-1:0];
        s2_next.row    = s1_row_reg[POS_W-1:0];
        s2_next.inten1 = bwl_reg;
        s2_next.inten2 = s1_cur_reg;
        if (s1_gv_reg) begin
            s2_next.gx = $signed({1'b0, q0_reg}) - $signed({1'b0, bw1_reg});
            s2_next.gy = $signed({1'b0, s1_cur_reg}) - $signed({1'b0, q1_reg});
        end
    end

    assign avg_sum = {2'b00, s1_cur_reg} + {2'b00, b1_reg} + {2'b00, bwl_reg}
                     + {2'b00, bw1_reg};
    assign px = s2_reg.gx * s2_reg.gx;
    assign py = s2_reg.gy * s2_reg.gy;

    always_comb begin
        push_b     = s3_reg;
        push_b.gsq = sqx_reg + sqy_reg;
    end

    always_ff @(posedge aclk) begin
        if (acc_act) ring[pos_reg] <= in_data;
        if (acc_act || ph_reg) q0_reg <= ring[rd0_addr];
        if (acc_act) q1_reg <= ring[rd1_addr];
        if (s3_valid_reg) fifo[wr_ptr_reg] <= push_b;
    end

    always_ff @(posedge aclk) begin
        if (acc_act) begin
            s1_cur_reg  <= in_data;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_pos_reg  <= pos_reg;
            s1_r1v_reg  <= f_r1v;
            s1_r2v_reg  <= f_r2v;
            s1_gv_reg   <= f_gv;
            s1_prod_reg <= prod_new;
        end
        if (ph_reg) bwl_reg <= q0_reg;
        if (st2_reg) begin
            s2_reg  <= s2_next;
            b1_reg  <= s1_cur_reg;
            bw1_reg <= bwl_reg;
        end
        if (handoff) nxt_data_reg <= avg_sum[PIX_W+1:2];
        if (s2_valid_reg) begin
            s3_reg  <= s2_reg;
            sqx_reg <= px[SQ_W-1:0];
            sqy_reg <= py[SQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            pos_reg       <= '0;
            ph_reg        <= 1'b0;
            st2_reg       <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            nxt_valid_reg <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            infl_reg      <= '0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            pos_reg      <= pos_next;
            ph_reg       <= acc_act;
            st2_reg      <= ph_reg;
            s2_valid_reg <= st2_reg;
            s3_valid_reg <= s2_valid_reg;
            if (handoff) begin
                nxt_valid_reg <= 1'b1;
            end else if (nxt_ready) begin
                nxt_valid_reg <= 1'b0;
            end
            if (s3_valid_reg) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg  <= cnt_reg + (FW+1)'(s3_valid_reg) - (FW+1)'(pop);
            infl_reg <= infl_reg + (FW+1)'(acc_act) - (FW+1)'(s3_valid_reg);
        end
    end

    assign nxt_valid  = nxt_valid_reg;
    assign nxt_data   = nxt_data_reg;
    assign head_valid = cnt_reg != '0;
    assign head       = fifo[rd_ptr_reg];

    a_fifo_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (cnt_reg < (FW+1)'(FIFO_DEPTH) || pop))
        else $error("result queue overflow");

    a_handoff_free: assert property (@(posedge aclk) disable iff (!aresetn)
        handoff |-> !nxt_valid_reg)
        else $error("handoff overwrites a pending pixel");

    a_top_level_no_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        (LVL == MAX_LEVELS - 1) |-> !nxt_valid_reg)
        else $error("coarsest level produced a pixel");

endmodule
`default_nettype wire

// ----- src/ipg_seq.sv -----
// Result sequencer: walks the level queues in order and marks the last result of each pixel.
`default_nettype none
module ipg_seq
    import ipg_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    head_valid [MAX_LEVELS],
    input  bundle_t      head       [MAX_LEVELS],
    output logic         pop        [MAX_LEVELS],
    output logic         m_valid,
    input  wire logic    m_ready,
    output res_t         m_res,
    output logic         m_last
);

    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    logic [LW-1:0] lvl_reg, lvl_next;
    logic          slot_reg, slot_next;
    logic          pend_valid_reg, pend_valid_next, pend_last_reg, pend_last_next;
    res_t          pend_reg, pend_next;
    logic          m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    res_t          m_res_reg, m_res_next;

    bundle_t hb;
    logic    hv, use1, has_res, more, run_end, out_free, can_res, take, flush;
    res_t    cand;

    assign hb       = head[lvl_reg];
    assign hv       = head_valid[lvl_reg];
    assign use1     = !slot_reg && hb.res1_v;
    assign has_res  = use1 || hb.res2_v;
    assign more     = use1 && hb.res2_v;
    assign run_end  = !more && !hb.cont;
    assign out_free = !m_valid_reg || m_ready;
    assign can_res  = !pend_valid_reg || (!pend_last_reg && out_free);
    assign take     = hv && (!has_res || can_res);
    assign flush    = pend_valid_reg && pend_last_reg && out_free;

    always_comb begin
        cand        = '0;
        cand.level  = LVL_W'(lvl_reg);
        cand.col    = hb.col;
        if (use1) begin
            cand.row    = hb.row - 1'b1;
            cand.inten  = hb.inten1;
            cand.gx     = hb.gx;
            cand.gy     = hb.gy;
            cand.gsq    = hb.gsq;
            cand.gvalid = hb.gvalid;
        end else begin
            cand.row    = hb.row;
            cand.inten  = hb.inten2;
        end
    end

    always_comb begin
        lvl_next        = lvl_reg;
        slot_next       = slot_reg;
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_last_next     = m_last_reg;
        m_res_next      = m_res_reg;
        for (int i = 0; i < MAX_LEVELS; i++) pop[i] = 1'b0;

        if (flush) begin
            m_valid_next    = 1'b1;
            m_res_next      = pend_reg;
            m_last_next     = 1'b1;
            pend_valid_next = 1'b0;
        end

        if (take) begin
            if (has_res) begin
                if (pend_valid_reg) begin
                    m_valid_next = 1'b1;
                    m_res_next   = pend_reg;
                    m_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_next       = cand;
                pend_last_next  = run_end;
            end else if (run_end && pend_valid_reg) begin
                pend_last_next = 1'b1;
            end
            if (more) begin
                slot_next = 1'b1;
            end else begin
                slot_next     = 1'b0;
                pop[lvl_reg]  = 1'b1;
                lvl_next      = hb.cont ? lvl_reg + 1'b1 : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg  <= pend_next;
        m_res_reg <= m_res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg        <= '0;
            slot_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_last_reg     <= 1'b0;
        end else begin
            lvl_reg        <= lvl_next;
            slot_reg       <= slot_next;
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
            m_valid_reg    <= m_valid_next;
            m_last_reg     <= m_last_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;
    assign m_last  = m_last_reg;

    a_pend_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && has_res && pend_valid_reg) |-> out_free && !pend_last_reg)
        else $error("pending result dropped");

    a_slot_only_mid_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg |-> hv && hb.res1_v && hb.res2_v)
        else $error("second slot without a two-result bundle");

    a_out_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg && $stable(m_res_reg))
        else $error("stalled result changed");

endmodule
`default_nettype wire

// ----- verif/image_pyramid_gradient_tb.sv -----
// Testbench for image_pyramid_gradient: stream driver, result monitor and pyramid predictor.
`default_nettype none
module image_pyramid_gradient_tb;
    import ipg_pkg::*;

    localparam int RING_SIZE = 4 * MAX_WIDTH_DEF + 2 * MAX_LEVELS_DEF;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [LVL_W-1:0]  level;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic [PIX_W-1:0]  inten;
        logic [GRAD_W-1:0] gx;
        logic [GRAD_W-1:0] gy;
        logic [SQ_W-1:0]   gsq;
        logic              gvalid;
        logic              last;
    } pyr_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    logic [PIX_W-1:0]  pixel_q[$];
    pyr_result_t       pyramid_q[$];
    logic [PIX_W-1:0]  ring_mem [RING_SIZE];
    int unsigned       lvl_col [MAX_LEVELS_DEF];
    int unsigned       lvl_row [MAX_LEVELS_DEF];
    int unsigned       img_w = WIDTH_RST;
    int unsigned       img_h = HEIGHT_RST;
    int unsigned       img_levels = LEVELS_RST;
    int                idle_mode = 0;
    int                errors = 0;
    int                pixels_sent = 0;
    int                results_seen = 0;
    int                phases_run = 0;
    logic              hold_start = 1'b0;
    int                hold_left = 0;

    image_pyramid_gradient DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [PIX_W-1:0] ring_at(int unsigned base, int unsigned pos,
                                                  int unsigned span, int unsigned back);
        return ring_mem[(base + (pos + span - back) % span) % RING_SIZE];
    endfunction

    function automatic pyr_result_t make_result(int unsigned l, int unsigned c, int unsigned r,
                                                int unsigned inten, int gx, int gy, bit v);
        pyr_result_t e;
        longint sq;
        sq = longint'(gx) * gx + longint'(gy) * gy;
        e.level = l[LVL_W-1:0];
        e.col = c[POS_W-1:0];
        e.row = r[POS_W-1:0];
        e.inten = inten[PIX_W-1:0];
        e.gx = gx[GRAD_W-1:0];
        e.gy = gy[GRAD_W-1:0];
        e.gsq = sq[SQ_W-1:0];
        e.gvalid = v;
        e.last = 1'b0;
        return e;
    endfunction

    function automatic void predict_pyramid(logic [PIX_W-1:0] px);
        int unsigned w0, h0, nlev, cur, base, wl, hl, span, c, r, pos, nv;
        int gx, gy;
        bit produce;
        pyr_result_t found[$];
        w0 = img_w > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : img_w;
        h0 = img_h > MAX_HEIGHT ? MAX_HEIGHT : img_h;
        nlev = img_levels == 0 ? 1 : img_levels;
        if (nlev > MAX_LEVELS_DEF) nlev = MAX_LEVELS_DEF;
        cur = px;
        base = 0;
        for (int unsigned l = 0; l < nlev; l++) begin
            wl = w0 >> l;
            hl = h0 >> l;
            if (wl == 0 || hl == 0) break;
            span = 2 * wl + 1;
            c = lvl_col[l];
            r = lvl_row[l];
            pos = (r * wl + c) % span;
            ring_mem[(base + pos) % RING_SIZE] = cur[PIX_W-1:0];
            if (r >= 1) begin
                if (r >= 2) begin
                    gx = int'(ring_at(base, pos, span, wl - 1)) - int'(ring_at(base, pos, span, wl + 1));
                    gy = int'(cur) - int'(ring_at(base, pos, span, 2 * wl));
                    found.push_back(make_result(l, c, r - 1, ring_at(base, pos, span, wl), gx, gy, 1'b1));
                end else begin
                    found.push_back(make_result(l, c, r - 1, ring_at(base, pos, span, wl), 0, 0, 1'b0));
                end
            end
            if (r + 1 == hl) found.push_back(make_result(l, c, r, cur, 0, 0, 1'b0));
            produce = (l + 1 < nlev) && c[0] && r[0] &&
                      ((c >> 1) < (w0 >> (l + 1))) && ((r >> 1) < (h0 >> (l + 1)));
            nv = 0;
            if (produce)
                nv = (cur + ring_at(base, pos, span, 1) + ring_at(base, pos, span, wl) +
                      ring_at(base, pos, span, wl + 1)) >> 2;
            c++;
            if (c >= wl) begin
                c = 0;
                r++;
                if (r >= hl) r = 0;
            end
            lvl_col[l] = c;
            lvl_row[l] = r;
            if (!produce) break;
            cur = nv;
            base += 2 * (MAX_WIDTH_DEF >> l) + 1;
        end
        if (found.size() > 0) found[found.size() - 1].last = 1'b1;
        foreach (found[i]) pyramid_q.push_back(found[i]);
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                predict_pyramid(s_axis_tdata);
                pixels_sent++;
            end
            if (pixel_q.size() > 0 &&
                !((idle_mode == 1 && $urandom_range(99) < 45) ||
                  (idle_mode == 3 && $urandom_range(99) < 7))) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pixel_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (hold_start) hold_left <= 400;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_axis_tready <= 1'b0;
        else m_axis_tready <= !(hold_start || hold_left > 1 ||
                                (idle_mode == 2 && $urandom_range(99) < 45) ||
                                (idle_mode == 3 && $urandom_range(99) < 7));
    end

    // monitor
    always @(posedge aclk) begin
        pyr_result_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pyramid_q.size() == 0) begin
                $error("unexpected result transaction: tdata=%h", m_axis_tdata);
                errors++;
            end else begin
                e = pyramid_q.pop_front();
                if (m_axis_tdata[2:0] !== e.level) begin
                    $error("level: expected %0d, got %0d", e.level, m_axis_tdata[2:0]); errors++;
                end
                if (m_axis_tdata[12:3] !== e.col) begin
                    $error("col: expected %0d, got %0d", e.col, m_axis_tdata[12:3]); errors++;
                end
                if (m_axis_tdata[22:13] !== e.row) begin
                    $error("row: expected %0d, got %0d", e.row, m_axis_tdata[22:13]); errors++;
                end
                if (m_axis_tdata[38:23] !== e.inten) begin
                    $error("intensity: expected %h, got %h", e.inten, m_axis_tdata[38:23]); errors++;
                end
                if (m_axis_tdata[55:39] !== e.gx) begin
                    $error("grad_x: expected %h, got %h", e.gx, m_axis_tdata[55:39]); errors++;
                end
                if (m_axis_tdata[72:56] !== e.gy) begin
                    $error("grad_y: expected %h, got %h", e.gy, m_axis_tdata[72:56]); errors++;
                end
                if (m_axis_tdata[105:73] !== e.gsq) begin
                    $error("grad_sq: expected %h, got %h", e.gsq, m_axis_tdata[105:73]); errors++;
                end
                if (m_axis_tdata[106] !== e.gvalid) begin
                    $error("grad_valid: expected %b, got %b", e.gvalid, m_axis_tdata[106]); errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_of_run: expected %b, got %b", e.last, m_axis_tlast); errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[DIM_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx != REG_SPARE) begin
            if (idx == REG_WIDTH) img_w = value & 11'h7FF;
            else if (idx == REG_HEIGHT) img_h = value & 11'h7FF;
            else img_levels = value & 3'h7;
            foreach (lvl_col[i]) begin
                lvl_col[i] = 0;
                lvl_row[i] = 0;
            end
        end
    endtask

    task automatic drain;
        while (pixel_q.size() > 0 || s_axis_tvalid || pyramid_q.size() > 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic run_phase(int unsigned w, int unsigned h, int unsigned lv, int npix, bit extreme);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_LEVELS, lv);
        if ($urandom_range(3) == 0) write_reg(REG_SPARE, $urandom_range(2047));
        for (int i = 0; i < npix; i++)
            pixel_q.push_back(extreme ? (i[0] ^ i[2] ? 16'hFFFF : 16'h0000) : 16'($urandom));
        phases_run++;
    endtask

    initial begin
        int unsigned w, h, lv, n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: tiny frames with extreme values, two levels and then one
        run_phase(4, 4, 2, 16, 1'b1);
        run_phase(2, 3, 0, 8, 1'b1);
        // full 8x8 frame, level count set above the maximum, with a long receiver hold-off
        idle_mode = 0;
        run_phase(8, 8, 7, 64, 1'b0);
        repeat (20) @(posedge aclk);
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        for (int p = 0; pixels_sent < 240 || p < 4; p++) begin
            drain();
            idle_mode = p % 4;
            case ($urandom_range(9))
                0: begin w = 1024 + $urandom_range(1023); h = $urandom_range(8); end
                1: begin w = $urandom_range(8); h = 64 + $urandom_range(1983); end
                2: begin w = 0; h = $urandom_range(8); end
                default: begin w = 1 + $urandom_range(15); h = 1 + $urandom_range(9); end
            endcase
            lv = $urandom_range(7);
            n = (w * h < 80 && w * h > 0) ? w * h * (1 + $urandom_range(1)) : 40;
            run_phase(w, h, lv, n, 1'b0);
        end
        drain();
        $display("Ran %0d phases: %0d pixels in, %0d pyramid results checked, %0d errors.",
                 phases_run, pixels_sent, results_seen, errors);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
src/ipg_pkg.sv
src/ipg_cell.sv
src/ipg_seq.sv
src/image_pyramid_gradient.sv
verif/image_pyramid_gradient_tb.sv
